>>> design/ffa_pkg.sv
// Package for the first-fit free-list allocator: default sizes, status codes,
// and the command and status structs between controller and datapath. No dependencies.
package ffa_pkg;

    localparam int unsigned HEAP_WORDS_DEF = 4096;
    localparam int unsigned LIST_DEPTH_DEF = 64;
    localparam int unsigned MAX_REQ_DEF    = 15;

    // Result status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Extent memory read address selection.
    localparam logic [1:0] RD_IDX  = 2'd0;
    localparam logic [1:0] RD_NEXT = 2'd1;
    localparam logic [1:0] RD_PREV = 2'd2;

    // Extent memory write data selection.
    localparam logic [1:0] WR_SHRINK = 2'd0;
    localparam logic [1:0] WR_COPY   = 2'd1;
    localparam logic [1:0] WR_NEW    = 2'd2;
    localparam logic [1:0] WR_INIT   = 2'd3;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       idx_inc;
        logic       idx_dec;
        logic       idx_to_total;
        logic       total_inc;
        logic       total_dec;
        logic       take_base;
        logic       set_status;
        logic [1:0] status_code;
        logic       res_load;
        logic       occ_wr;
        logic       occ_bit;
    } cmd_t;

    typedef struct packed {
        logic op_free;
        logic size_bad;
        logic free_empty;
        logic list_full;
        logic idx_lt_total;
        logic idx_p1_lt_total;
        logic idx_zero;
        logic fit_ge;
        logic fit_eq;
        logic out_busy;
        logic mark_last;
        logic clear_last;
    } stat_t;

endpackage

>>> design/ffa_ctrl.sv
// Controller state machine of the allocator: sequences scan, map marking, delete and push.
// Depends on ffa_pkg for the command and status structs and codes.
module ffa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ffa_pkg::stat_t st,
    output ffa_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DECODE   = 4'd2;
    localparam logic [3:0] S_SCAN_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_CHK = 4'd4;
    localparam logic [3:0] S_DEL_RD   = 4'd5;
    localparam logic [3:0] S_DEL_WR   = 4'd6;
    localparam logic [3:0] S_PUSH_RD  = 4'd7;
    localparam logic [3:0] S_PUSH_WR  = 4'd8;
    localparam logic [3:0] S_RESULT   = 4'd9;
    localparam logic [3:0] S_MARK     = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                // Clear the occupancy map one word a cycle. The last cycle also
                // makes entry 0 the extent that spans the whole heap.
                cmd.occ_wr  = 1'b1;
                cmd.occ_bit = 1'b0;
                if (st.clear_last)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = ffa_pkg::WR_INIT;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!st.op_free)
                begin
                    if (st.size_bad)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ffa_pkg::ST_NOFIT;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
                else if (st.free_empty)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ffa_pkg::ST_DONE;
                    state_next      = S_RESULT;
                end
                else if (st.list_full)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ffa_pkg::ST_FULL;
                    state_next      = S_RESULT;
                end
                else
                begin
                    cmd.idx_to_total = 1'b1;
                    state_next       = S_MARK;
                end
            end
            S_SCAN_RD:
            begin
                if (st.idx_lt_total)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ffa_pkg::RD_IDX;
                    state_next = S_SCAN_CHK;
                end
                else
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ffa_pkg::ST_NOFIT;
                    state_next      = S_RESULT;
                end
            end
            S_SCAN_CHK:
            begin
                if (st.fit_ge)
                begin
                    cmd.take_base   = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ffa_pkg::ST_DONE;
                    state_next      = S_MARK;
                    if (!st.fit_eq)
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = ffa_pkg::WR_SHRINK;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_MARK:
            begin
                // One map word per cycle: set for an allocate, cleared for a free.
                cmd.occ_wr  = 1'b1;
                cmd.occ_bit = !st.op_free;
                if (st.mark_last)
                begin
                    if (st.op_free)
                    begin
                        state_next = S_PUSH_RD;
                    end
                    else if (st.fit_eq)
                    begin
                        state_next = S_DEL_RD;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_DEL_RD:
            begin
                if (st.idx_p1_lt_total)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ffa_pkg::RD_NEXT;
                    state_next = S_DEL_WR;
                end
                else
                begin
                    cmd.total_dec = 1'b1;
                    state_next    = S_RESULT;
                end
            end
            S_DEL_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = ffa_pkg::WR_COPY;
                cmd.idx_inc = 1'b1;
                state_next  = S_DEL_RD;
            end
            S_PUSH_RD:
            begin
                if (st.idx_zero)
                begin
                    cmd.wr_en       = 1'b1;
                    cmd.wr_sel      = ffa_pkg::WR_NEW;
                    cmd.total_inc   = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ffa_pkg::ST_DONE;
                    state_next      = S_RESULT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ffa_pkg::RD_PREV;
                    state_next = S_PUSH_WR;
                end
            end
            S_PUSH_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = ffa_pkg::WR_COPY;
                cmd.idx_dec = 1'b1;
                state_next  = S_PUSH_RD;
            end
            S_RESULT:
            begin
                if (!st.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE))
        else $error("input taken outside idle");
    a_decode_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_DECODE))
        else $error("load not followed by decode");
    a_result_one_hot_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !(cmd.wr_en || cmd.rd_en || cmd.load))
        else $error("result load overlaps list access");
`endif

endmodule

>>> design/ffa_datapath.sv
// Datapath of the allocator: extent memory, occupancy map, list count, index,
// request and output registers. Depends on ffa_pkg for the command and status structs.
module ffa_datapath #(
    parameter int unsigned HEAP_WORDS = ffa_pkg::HEAP_WORDS_DEF,
    parameter int unsigned LIST_DEPTH = ffa_pkg::LIST_DEPTH_DEF,
    parameter int unsigned MAX_REQ    = ffa_pkg::MAX_REQ_DEF,
    localparam int unsigned AW = $clog2(HEAP_WORDS),
    localparam int unsigned LW = $clog2(HEAP_WORDS + 1),
    localparam int unsigned SW = $clog2(MAX_REQ + 1),
    localparam int unsigned CW = $clog2(LIST_DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ffa_pkg::cmd_t  cmd,
    output ffa_pkg::stat_t st,
    input  logic          action,
    input  logic [AW-1:0] block_addr,
    input  logic [SW-1:0] req_size,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    status,
    output logic [AW-1:0] granted_addr,
    output logic [CW-1:0] extent_count
);

    localparam int unsigned IW = $clog2(LIST_DEPTH);
    localparam int unsigned XW = (LW > SW) ? LW : SW;
    localparam int unsigned EW = AW + LW;

    logic [EW-1:0] ext_mem [LIST_DEPTH];
    logic [EW-1:0] rd_q_reg;
    logic [EW-1:0] wr_data;
    logic [IW-1:0] rd_addr;

    logic          occ_mem [HEAP_WORDS];
    logic [AW-1:0] occ_ptr_reg;
    logic [LW-1:0] mark_cnt_reg;

    logic [CW-1:0] total_reg;
    logic [CW-1:0] idx_reg;
    logic          op_reg;
    logic [AW-1:0] addr_reg;
    logic [SW-1:0] size_reg;
    logic          empty_reg;
    logic [AW-1:0] base_reg;
    logic [1:0]    stat_reg;

    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic [AW-1:0] granted_reg;
    logic [CW-1:0] count_reg;

    logic [AW-1:0] q_start;
    logic [LW-1:0] q_len;
    logic [XW-1:0] q_len_x;
    logic [XW-1:0] size_x;
    logic [XW-1:0] room_x;
    logic [XW-1:0] req_x;
    logic          addr_out;
    logic [SW-1:0] clip_size;

    assign q_start = rd_q_reg[EW-1:LW];
    assign q_len   = rd_q_reg[LW-1:0];
    assign q_len_x = XW'(q_len);
    assign size_x  = XW'(size_reg);

    // Clip a free at the heap end.
    assign addr_out = (LW'(block_addr) >= LW'(HEAP_WORDS));
    assign room_x   = XW'(LW'(HEAP_WORDS) - LW'(block_addr));
    assign req_x    = XW'(req_size);

    always_comb
    begin
        if (action && (req_x > room_x))
        begin
            clip_size = SW'(room_x);
        end
        else
        begin
            clip_size = req_size;
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            ffa_pkg::RD_NEXT: rd_addr = IW'(idx_reg + CW'(1));
            ffa_pkg::RD_PREV: rd_addr = IW'(idx_reg - CW'(1));
            default:          rd_addr = idx_reg[IW-1:0];
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            ffa_pkg::WR_SHRINK: wr_data = {AW'(q_start + AW'(size_reg)),
                                           LW'(q_len - LW'(size_reg))};
            ffa_pkg::WR_COPY:   wr_data = rd_q_reg;
            ffa_pkg::WR_NEW:    wr_data = {addr_reg, LW'(size_reg)};
            default:            wr_data = {AW'(0), LW'(HEAP_WORDS)};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            ext_mem[idx_reg[IW-1:0]] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_q_reg <= ext_mem[rd_addr];
        end
        if (cmd.occ_wr)
        begin
            occ_mem[occ_ptr_reg] <= cmd.occ_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= CW'(1);
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            occ_ptr_reg   <= '0;
            mark_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.total_inc)
            begin
                total_reg <= total_reg + CW'(1);
            end
            else if (cmd.total_dec)
            begin
                total_reg <= total_reg - CW'(1);
            end
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_to_total)
            begin
                idx_reg <= total_reg;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_reg - CW'(1);
            end
            // The map pointer starts at the free address or the granted base.
            if (cmd.load)
            begin
                occ_ptr_reg  <= block_addr;
                mark_cnt_reg <= '0;
            end
            else if (cmd.take_base)
            begin
                occ_ptr_reg <= q_start;
            end
            else if (cmd.occ_wr)
            begin
                occ_ptr_reg  <= occ_ptr_reg + AW'(1);
                mark_cnt_reg <= mark_cnt_reg + LW'(1);
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= action;
            addr_reg  <= block_addr;
            size_reg  <= clip_size;
            empty_reg <= addr_out || (clip_size == '0);
            base_reg  <= '0;
        end
        else if (cmd.take_base)
        begin
            base_reg <= q_start;
        end
        if (cmd.set_status)
        begin
            stat_reg <= cmd.status_code;
        end
        if (cmd.res_load)
        begin
            status_reg  <= stat_reg;
            granted_reg <= base_reg;
            count_reg   <= total_reg;
        end
    end

    always_comb
    begin
        st.op_free         = op_reg;
        st.size_bad        = (size_reg == '0) || (size_x > XW'(MAX_REQ));
        st.free_empty      = empty_reg;
        st.list_full       = (total_reg >= CW'(LIST_DEPTH));
        st.idx_lt_total    = (idx_reg < total_reg);
        st.idx_p1_lt_total = ((idx_reg + CW'(1)) < total_reg);
        st.idx_zero        = (idx_reg == '0);
        st.fit_ge          = (q_len_x >= size_x);
        st.fit_eq          = (q_len_x == size_x);
        st.out_busy        = out_valid_reg && !out_ready;
        st.mark_last       = ((mark_cnt_reg + LW'(1)) == LW'(size_reg));
        st.clear_last      = (mark_cnt_reg == LW'(HEAP_WORDS - 1));
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign granted_addr = granted_reg;
    assign extent_count = count_reg;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(LIST_DEPTH))
        else $error("extent count above list depth");
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ffa_pkg::ST_FULL)) |-> (extent_count == CW'(LIST_DEPTH)))
        else $error("full status with room in list");
    a_nofit_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ffa_pkg::ST_NOFIT)) |-> (granted_addr == '0))
        else $error("address granted on no-fit");
    a_occ_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.occ_wr |=> (occ_mem[$past(occ_ptr_reg)] == $past(cmd.occ_bit)))
        else $error("occupancy map word not written");
`endif

endmodule

>>> design/first_fit_free_list_allocator_unit.sv
// Top level of the first-fit free-list allocator.
// Depends on ffa_pkg, ffa_ctrl and ffa_datapath.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+------------------------------------
//  input   | in        | in_valid / in_ready | action, block_addr, req_size
//  output  | out       | out_valid/out_ready | status, granted_addr, extent_count
//
// Every request yields exactly one result transfer. After reset the block
// clears the occupancy map one word a cycle and writes the first extent
// with the last map word; no transfer is accepted before that.
// The extent memory has one read and one write port. An allocate reads and
// checks each extent in turn up to the first fit, marks one map word per
// cycle, and on an exact fit closes the gap by copying each later extent
// down one place. A free clears one map word per cycle and pushes at the
// head, moving every extent up one place. A rejected request goes from
// decode straight to the result. The result sits in an output register, so
// a new request is taken while an earlier result waits; the block stalls
// only when a new result is ready and the old one is not yet taken.
module first_fit_free_list_allocator_unit #(
    parameter int unsigned HEAP_WORDS = ffa_pkg::HEAP_WORDS_DEF,
    parameter int unsigned LIST_DEPTH = ffa_pkg::LIST_DEPTH_DEF,
    parameter int unsigned MAX_REQ    = ffa_pkg::MAX_REQ_DEF,
    localparam int unsigned AW = $clog2(HEAP_WORDS),
    localparam int unsigned SW = $clog2(MAX_REQ + 1),
    localparam int unsigned CW = $clog2(LIST_DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          action,
    input  logic [AW-1:0] block_addr,
    input  logic [SW-1:0] req_size,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    status,
    output logic [AW-1:0] granted_addr,
    output logic [CW-1:0] extent_count
);

    ffa_pkg::cmd_t  cmd;
    ffa_pkg::stat_t st;

    // The controller sequences each request; the datapath holds the list and the map.
    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    ffa_datapath #(
        .HEAP_WORDS (HEAP_WORDS),
        .LIST_DEPTH (LIST_DEPTH),
        .MAX_REQ    (MAX_REQ)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .action       (action),
        .block_addr   (block_addr),
        .req_size     (req_size),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .granted_addr (granted_addr),
        .extent_count (extent_count)
    );

endmodule

>>> verif/tb.sv
// Self-checking testbench for first_fit_free_list_allocator_unit.
// Depends on ffa_pkg and the allocator RTL. A behavioral copy of the free list
// predicts results not typed in, and each output transfer is compared field by field.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP  = 4096;
    localparam int DEPTH = 64;
    localparam int MAXSZ = 15;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 2000;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [1:0]  st;
        logic [11:0] addr;
        logic [6:0]  count;
    } alloc_result_t;

    typedef struct {
        logic          op;
        logic [11:0]   addr;
        logic [3:0]    size;
        bit            known;
        alloc_result_t want;
    } stim_row_t;

    typedef struct packed {
        logic [11:0] addr;
        logic [3:0]  size;
    } live_block_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [11:0] block_addr;
    logic [3:0]  req_size;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [11:0] granted_addr;
    logic [6:0]  extent_count;

    first_fit_free_list_allocator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .block_addr   (block_addr),
        .req_size     (req_size),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .granted_addr (granted_addr),
        .extent_count (extent_count)
    );

    // The predictor's own copy of the free list. The occupancy map never
    // shows up on an output, so only the list is mirrored here.
    int unsigned list_start [DEPTH];
    int unsigned list_len   [DEPTH];
    int unsigned list_total;

    alloc_result_t pending_results[$];
    live_block_t   live_blocks[$];

    int mismatches;
    int results_seen;
    int nofit_seen;
    int full_seen;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Work out the result of one request and update the mirrored list. An
    // allocate of zero or an oversized request, and a request that finds no
    // long enough extent, leave the list alone. A free is clipped at the
    // heap end, an empty free does nothing, and a free into a full list is
    // rejected as a whole.
    function automatic alloc_result_t predict_allocation(logic op, logic [11:0] addr,
                                                         logic [3:0] size);
        alloc_result_t r;
        int unsigned   n;
        int unsigned   k;
        int unsigned   j;
        int unsigned   base;
        r.st   = ffa_pkg::ST_NOFIT;
        r.addr = '0;
        if (op == OP_ALLOC)
        begin
            if (size != 0 && size <= MAXSZ)
            begin
                for (k = 0; k < list_total; k++)
                begin
                    if (list_len[k] >= size)
                    begin
                        base = list_start[k];
                        if (list_len[k] == size)
                        begin
                            for (j = k; j + 1 < list_total; j++)
                            begin
                                list_start[j] = list_start[j + 1];
                                list_len[j]   = list_len[j + 1];
                            end
                            list_total--;
                        end
                        else
                        begin
                            list_start[k] = base + size;
                            list_len[k]   = list_len[k] - size;
                        end
                        r.st   = ffa_pkg::ST_DONE;
                        r.addr = base[11:0];
                        break;
                    end
                end
            end
        end
        else
        begin
            n = size;
            if (n > HEAP - addr)
                n = HEAP - addr;
            r.st = ffa_pkg::ST_DONE;
            if (n != 0)
            begin
                if (list_total >= DEPTH)
                    r.st = ffa_pkg::ST_FULL;
                else
                begin
                    for (j = list_total; j > 0; j--)
                    begin
                        list_start[j] = list_start[j - 1];
                        list_len[j]   = list_len[j - 1];
                    end
                    list_start[0] = addr;
                    list_len[0]   = n;
                    list_total++;
                end
            end
        end
        r.count = list_total[6:0];
        return r;
    endfunction

    // Present one request and hold it until the transfer happens, then
    // record what the block should answer. A typed-in expectation takes the
    // place of the predicted one, though the predictor still sees the request.
    task automatic send_request(logic op, logic [11:0] addr, logic [3:0] size,
                                bit known, alloc_result_t want);
        alloc_result_t r;
        int gap;
        in_valid   <= 1'b1;
        action     <= op;
        block_addr <= addr;
        req_size   <= size;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = predict_allocation(op, addr, size);
        pending_results.push_back(known ? want : r);
        if (op == OP_ALLOC && r.st == ffa_pkg::ST_DONE)
            live_blocks.push_back({r.addr, size});
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid   <= 1'b0;
            block_addr <= 12'($urandom);
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Mostly well-formed traffic: allocate, then give back blocks that were
    // really granted. The rest is noise: frees of arbitrary ranges, zero
    // sizes, and ranges hanging off the end of the heap.
    task automatic send_random_request();
        alloc_result_t none;
        live_block_t   b;
        int            pick;
        int            idx;
        none = '0;
        pick = $urandom_range(99);
        if (pick < 55)
            send_request(OP_ALLOC, 12'($urandom),
                         ($urandom_range(19) == 0) ? 4'd0 : 4'($urandom_range(1, MAXSZ)),
                         1'b0, none);
        else if (pick < 85 && live_blocks.size() > 0)
        begin
            idx = $urandom_range(live_blocks.size() - 1);
            b = live_blocks[idx];
            live_blocks.delete(idx);
            send_request(OP_FREE, b.addr, b.size, 1'b0, none);
        end
        else if (pick < 92)
            send_request(OP_FREE, 12'($urandom_range(HEAP - 16, HEAP - 1)), 4'($urandom),
                         1'b0, none);
        else
            send_request(OP_FREE, 12'($urandom), 4'($urandom), 1'b0, none);
    endtask

    // Output side: random back-pressure, and every result transfer is
    // checked against the oldest pending expectation.
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n)
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (status == ffa_pkg::ST_NOFIT)
                    nofit_seen++;
                if (status == ffa_pkg::ST_FULL)
                    full_seen++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result st=%0d addr=%0d count=%0d",
                                 status, granted_addr, extent_count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.st || granted_addr !== want.addr
                        || extent_count !== want.count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: result %0d expected st=%0d addr=%0d count=%0d,",
                                      " got st=%0d addr=%0d count=%0d"},
                                     results_seen, want.st, want.addr, want.count,
                                     status, granted_addr, extent_count);
                    end
                end
            end
        end
    end

    // Watchdog: cycles in a row with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding",
                     pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        int        phase;
        int        i;
        int        drain;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = OP_ALLOC;
        block_addr     = '0;
        req_size       = '0;
        out_ready      = 1'b0;
        mismatches     = 0;
        results_seen   = 0;
        nofit_seen     = 0;
        full_seen      = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        list_start[0]  = 0;
        list_len[0]    = HEAP;
        list_total     = 1;

        // Directed part. Early rows can be read straight off the reset state:
        // the first allocations carve the whole-heap extent from address zero.
        rows.push_back('{OP_ALLOC, 12'hABC, 4'd1,  1, '{ffa_pkg::ST_DONE, 12'd0, 7'd1}});
        rows.push_back('{OP_ALLOC, 12'h000, 4'd15, 1, '{ffa_pkg::ST_DONE, 12'd1, 7'd1}});
        rows.push_back('{OP_ALLOC, 12'h000, 4'd0,  1, '{ffa_pkg::ST_NOFIT, 12'd0, 7'd1}});
        // A free hanging off the end of the heap is clipped to one word.
        rows.push_back('{OP_FREE,  12'hFFF, 4'd15, 1, '{ffa_pkg::ST_DONE, 12'd0, 7'd2}});
        // A free of zero words changes nothing.
        rows.push_back('{OP_FREE,  12'h000, 4'd0,  1, '{ffa_pkg::ST_DONE, 12'd0, 7'd2}});
        // An exact fit on the head extent removes it.
        rows.push_back('{OP_ALLOC, 12'hFFF, 4'd1,  1, '{ffa_pkg::ST_DONE, 12'hFFF, 7'd1}});
        rows.push_back('{OP_FREE,  12'd1,   4'd15, 1, '{ffa_pkg::ST_DONE, 12'd0, 7'd2}});
        rows.push_back('{OP_ALLOC, 12'h555, 4'd8,  0, '0});
        rows.push_back('{OP_ALLOC, 12'h000, 4'd7,  0, '0});
        rows.push_back('{OP_FREE,  12'h000, 4'd15, 0, '0});
        // Freeing words that are already free is accepted and overlaps.
        rows.push_back('{OP_FREE,  12'h004, 4'd3,  0, '0});
        rows.push_back('{OP_ALLOC, 12'h000, 4'd15, 0, '0});
        rows.push_back('{OP_ALLOC, 12'h000, 4'd4,  0, '0});
        rows.push_back('{OP_FREE,  12'hFF0, 4'd15, 0, '0});
        rows.push_back('{OP_FREE,  12'h7FF, 4'd9,  0, '0});
        rows.push_back('{OP_ALLOC, 12'hFFF, 4'd15, 0, '0});
        rows.push_back('{OP_ALLOC, 12'h000, 4'd2,  0, '0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[k])
            send_request(rows[k].op, rows[k].addr, rows[k].size, rows[k].known, rows[k].want);

        // Random part in four handshake phases: free running, sender idling,
        // receiver stalling, then both.
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 70 : (phase == 3) ? 31 : 0;
            recv_stall_pct = (phase == 2) ? 70 : (phase == 3) ? 31 : 0;
            for (i = 0; i < RANDOM_ITEMS / 4; i++)
                send_random_request();
        end
        in_valid <= 1'b0;

        drain = 0;
        while (pending_results.size() > 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (300) @(posedge clk);

        $display("Ran %0d requests, %0d results checked (%0d no-fit, %0d list-full).",
                 rows.size() + RANDOM_ITEMS, results_seen, nofit_seen, full_seen);
        $display("%0d mismatches, %0d results never arrived.",
                 mismatches, pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
design/ffa_pkg.sv
design/ffa_ctrl.sv
design/ffa_datapath.sv
design/first_fit_free_list_allocator_unit.sv
verif/tb.sv
